[hw/rtl/dltq_pkg.sv]
package dltq_pkg;

	localparam int DLTQ_TIMERS = 16;

	typedef enum logic [1:0] {
		OP_REG       = 2'd0,
		OP_UNREG     = 2'd1,
		OP_UNREG_ALL = 2'd2,
		OP_TICK      = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SYNC0,
		ST_SYNC,
		ST_DISP,
		ST_SCAN,
		ST_REM,
		ST_INS0,
		ST_INS,
		ST_TICK
	} state_t;

endpackage

[hw/rtl/delta_list_timer_queue_top.sv]
// channel   direction  handshake            payload
// command   in         start && !busy       operation handler_id event_id period_us now_us
// result    out        strobe (one cycle)   status fired out_handler out_event last
//
// one transaction is the time sync, a slot scan over all TIMERS slots for the non-tick
// operations, and a remove and an insert walk per expired timer on a tick
// the delta subtract and compare units step the list one entry per cycle
// arst_n clears the list to empty, frees every slot and zeroes the saved time
// results cannot be stalled; strobe marks each for exactly one cycle, and the payload holds until the next result
module delta_list_timer_queue_top #(
	parameter int TIMERS = dltq_pkg::DLTQ_TIMERS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] handler_id,
	input  logic [15:0] event_id,
	input  logic [31:0] period_us,
	input  logic [47:0] now_us,
	output logic        strobe,
	output logic        status,
	output logic        fired,
	output logic [15:0] out_handler,
	output logic [15:0] out_event,
	output logic        last
);
	import dltq_pkg::*;

	localparam int IW = $clog2(TIMERS);
	localparam int SW = $clog2(TIMERS + 1);
	localparam logic [SW-1:0] NIL = SW'(TIMERS);
	localparam logic [IW-1:0] ILAST = IW'(TIMERS - 1);

	state_t state_q, nxt;
	op_t op_q;
	logic [15:0] h_q, e_q, ph_q, pe_q;
	logic [31:0] per_q, rem_q;
	logic [47:0] now_q, saved_q, el_q;
	logic [SW-1:0] first_q, p_q, prev_q, n_q;
	logic [IW-1:0] s_q, i_q, fidx_q, fridx_q;
	logic found_q, free_q, pend_q;
	logic [15:0] handler_q [TIMERS];
	logic [15:0] event_q [TIMERS];
	logic [31:0] period_q [TIMERS];
	logic [31:0] delta_q [TIMERS];
	logic [SW-1:0] link_q [TIMERS];

	logic [IW-1:0] rd_i, fi, fidx_n, fridx_n;
	logic [31:0] dp, dnx, dfirst;
	logic [SW-1:0] lp;
	logic p_nil, sync_gt, ins_gt, m, fr, fnd, frd, tick_go, at_s, hit_all;
	logic [15:0] hi, ei;
	logic em, em_status, em_fired, em_last;
	logic [15:0] em_h, em_e;

	assign rd_i = p_q[IW-1:0];
	assign dp = delta_q[rd_i];
	assign lp = link_q[rd_i];
	assign dnx = delta_q[lp[IW-1:0]];
	assign fi = first_q[IW-1:0];
	assign dfirst = delta_q[fi];
	assign p_nil = (p_q == NIL);
	assign sync_gt = (el_q > {16'd0, dp});
	assign ins_gt = (rem_q > dp);
	assign hi = handler_q[i_q];
	assign ei = event_q[i_q];
	assign m = (h_q != 16'd0) && (hi == h_q) && (ei == e_q);
	assign fr = (hi == 16'd0);
	assign fnd = found_q | m;
	assign frd = free_q | fr;
	assign fidx_n = found_q ? fidx_q : i_q;
	assign fridx_n = free_q ? fridx_q : i_q;
	assign tick_go = (first_q != NIL) && (dfirst == 32'd0) && (n_q < NIL);
	assign at_s = (p_q == SW'(s_q));
	assign hit_all = (hi == h_q);
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		nxt = state_q;
		em = 1'b0;
		em_status = 1'b0;
		em_fired = 1'b0;
		em_h = 16'd0;
		em_e = 16'd0;
		em_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					nxt = ST_SYNC0;
			end
			ST_SYNC0: begin
				nxt = (now_q < saved_q) ? ST_DISP : ST_SYNC;
			end
			ST_SYNC: begin
				if (p_nil || !sync_gt)
					nxt = ST_DISP;
			end
			ST_DISP: begin
				unique case (op_q)
					OP_REG: begin
						if (h_q == 16'd0 || per_q == 32'd0) begin
							em = 1'b1;
							em_status = 1'b1;
							nxt = ST_IDLE;
						end else begin
							nxt = ST_SCAN;
						end
					end
					OP_UNREG: nxt = ST_SCAN;
					OP_UNREG_ALL: begin
						if (h_q == 16'd0) begin
							em = 1'b1;
							nxt = ST_IDLE;
						end else begin
							nxt = ST_SCAN;
						end
					end
					OP_TICK: nxt = ST_TICK;
					default: nxt = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				if (op_q == OP_UNREG_ALL) begin
					if (hit_all) begin
						nxt = ST_REM;
					end else if (i_q == ILAST) begin
						em = 1'b1;
						nxt = ST_IDLE;
					end
				end else if (i_q == ILAST) begin
					if (fnd) begin
						nxt = ST_REM;
					end else if (op_q == OP_REG && frd) begin
						nxt = ST_INS0;
					end else begin
						em = 1'b1;
						em_status = 1'b1;
						nxt = ST_IDLE;
					end
				end
			end
			ST_REM: begin
				if (at_s || p_nil) begin
					unique case (op_q)
						OP_REG, OP_TICK: nxt = ST_INS0;
						OP_UNREG: begin
							em = 1'b1;
							nxt = ST_IDLE;
						end
						OP_UNREG_ALL: begin
							if (i_q == ILAST) begin
								em = 1'b1;
								nxt = ST_IDLE;
							end else begin
								nxt = ST_SCAN;
							end
						end
						default: nxt = ST_IDLE;
					endcase
				end
			end
			ST_INS0: nxt = ST_INS;
			ST_INS: begin
				if (p_nil || !ins_gt) begin
					if (op_q == OP_TICK) begin
						nxt = ST_TICK;
					end else begin
						em = 1'b1;
						nxt = ST_IDLE;
					end
				end
			end
			ST_TICK: begin
				if (tick_go) begin
					nxt = ST_REM;
					if (pend_q) begin
						em = 1'b1;
						em_fired = 1'b1;
						em_h = ph_q;
						em_e = pe_q;
						em_last = 1'b0;
					end
				end else begin
					em = 1'b1;
					nxt = ST_IDLE;
					if (pend_q) begin
						em_fired = 1'b1;
						em_h = ph_q;
						em_e = pe_q;
					end
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// control state, list head, saved time, result strobe and slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= NIL;
			saved_q <= 48'd0;
			strobe <= 1'b0;
			for (int k = 0; k < TIMERS; k++)
				handler_q[k] <= 16'd0;
		end else begin
			state_q <= nxt;
			strobe <= em;
			case (state_q)
				ST_SYNC0: saved_q <= now_q;
				ST_SCAN: begin
					if (op_q == OP_UNREG_ALL) begin
						if (hit_all)
							handler_q[i_q] <= 16'd0;
					end else if (i_q == ILAST) begin
						if (fnd) begin
							if (op_q == OP_UNREG)
								handler_q[fidx_n] <= 16'd0;
						end else if (op_q == OP_REG && frd) begin
							handler_q[fridx_n] <= h_q;
						end
					end
				end
				ST_REM: begin
					if (at_s && prev_q == NIL)
						first_q <= lp;
				end
				ST_INS: begin
					if ((p_nil || !ins_gt) && prev_q == NIL)
						first_q <= SW'(s_q);
				end
				default: ;
			endcase
		end
	end

	// list datapath, command capture and result payload
	always_ff @(posedge clk) begin
		if (em) begin
			status <= em_status;
			fired <= em_fired;
			out_handler <= em_h;
			out_event <= em_e;
			last <= em_last;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q <= op_t'(operation);
					h_q <= handler_id;
					e_q <= event_id;
					per_q <= period_us;
					now_q <= now_us;
				end
			end
			ST_SYNC0: begin
				el_q <= now_q - saved_q;
				p_q <= first_q;
			end
			ST_SYNC: begin
				if (!p_nil) begin
					if (sync_gt) begin
						el_q <= el_q - {16'd0, dp};
						delta_q[rd_i] <= 32'd0;
						p_q <= lp;
					end else begin
						delta_q[rd_i] <= dp - el_q[31:0];
					end
				end
			end
			ST_DISP: begin
				i_q <= '0;
				found_q <= 1'b0;
				free_q <= 1'b0;
				n_q <= '0;
				pend_q <= 1'b0;
			end
			ST_SCAN: begin
				if (op_q == OP_UNREG_ALL) begin
					if (hit_all) begin
						s_q <= i_q;
						p_q <= first_q;
						prev_q <= NIL;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end else begin
					found_q <= fnd;
					fidx_q <= fidx_n;
					free_q <= frd;
					fridx_q <= fridx_n;
					i_q <= i_q + 1'b1;
					if (i_q == ILAST) begin
						rem_q <= per_q;
						p_q <= first_q;
						prev_q <= NIL;
						if (fnd) begin
							s_q <= fidx_n;
							if (op_q == OP_REG) begin
								event_q[fidx_n] <= e_q;
								period_q[fidx_n] <= per_q;
							end
						end else begin
							s_q <= fridx_n;
							if (op_q == OP_REG && frd) begin
								event_q[fridx_n] <= e_q;
								period_q[fridx_n] <= per_q;
							end
						end
					end
				end
			end
			ST_REM: begin
				if (at_s) begin
					if (lp != NIL)
						delta_q[lp[IW-1:0]] <= dnx + dp;
					if (prev_q != NIL)
						link_q[prev_q[IW-1:0]] <= lp;
					if (op_q == OP_TICK)
						rem_q <= period_q[s_q];
					if (op_q == OP_UNREG_ALL)
						i_q <= i_q + 1'b1;
				end else if (!p_nil) begin
					prev_q <= p_q;
					p_q <= lp;
				end
			end
			ST_INS0: begin
				p_q <= first_q;
				prev_q <= NIL;
			end
			ST_INS: begin
				if (!p_nil && ins_gt) begin
					rem_q <= rem_q - dp;
					prev_q <= p_q;
					p_q <= lp;
				end else begin
					if (!p_nil)
						delta_q[rd_i] <= dp - rem_q;
					delta_q[s_q] <= rem_q;
					link_q[s_q] <= p_q;
					if (prev_q != NIL)
						link_q[prev_q[IW-1:0]] <= SW'(s_q);
				end
			end
			ST_TICK: begin
				if (tick_go) begin
					pend_q <= 1'b1;
					ph_q <= handler_q[fi];
					pe_q <= event_q[fi];
					s_q <= fi;
					p_q <= first_q;
					prev_q <= NIL;
					n_q <= n_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy) else $error("final result while still busy");
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy) else $error("non-final result after finishing");
	a_quiet_ids: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !fired |-> out_handler == 16'd0 && out_event == 16'd0)
		else $error("ids set on a result that did not fire");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction not started");
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && fired |-> !status) else $error("fired result with error status");
`endif

endmodule
